@@ hdl/rct_pkg.sv @@
// ----------------------------------------------------------------------------
// rct_pkg
// Shared constants, codes and controller/datapath types of the range count
// table.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int VALUE_BITS    = 30;
  localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
  localparam int IDX_BITS      = 11;
  localparam int USE_BITS      = 11;
  localparam int COUNT_BITS    = 11;
  localparam int PDATA_BITS    = 32;
  localparam int PADDR_BITS    = 3;
  localparam int ENTRIES_RESET = 1024;

  typedef enum logic {
    OP_SET   = 1'b0,
    OP_QUERY = 1'b1
  } rct_op_e;

  typedef enum logic {
    REG_ENTRIES_IN_USE = 1'b0,
    REG_UNUSED         = 1'b1
  } rct_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } rct_state_e;

  typedef struct packed {
    logic write_entry;
    logic start_query;
    logic issue;
    logic load_out;
  } rct_cmd_t;

  typedef struct packed {
    logic query_empty;
    logic last_issue;
    logic pipe_empty;
    logic out_free;
  } rct_sts_t;

endpackage

@@ hdl/rct_in_if.sv @@
// ----------------------------------------------------------------------------
// rct_in_if
// Input channel: one set or query item per transfer.
// ----------------------------------------------------------------------------
interface rct_in_if
  import rct_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [IDX_BITS-1:0]   entry_index;
  logic [VALUE_BITS-1:0] new_value;
  logic [VALUE_BITS-1:0] range_low;
  logic [VALUE_BITS-1:0] range_high;

  modport source (
    output valid, operation, entry_index, new_value, range_low, range_high,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, new_value, range_low, range_high,
    output ready
  );
endinterface

@@ hdl/rct_out_if.sv @@
// ----------------------------------------------------------------------------
// rct_out_if
// Output channel: one match count per transfer.
// ----------------------------------------------------------------------------
interface rct_out_if
  import rct_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] match_count;

  modport source (
    output valid, match_count,
    input  ready
  );
  modport sink (
    input  valid, match_count,
    output ready
  );
endinterface

@@ hdl/rct_ram.sv @@
// ----------------------------------------------------------------------------
// rct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/rct_ctrl.sv @@
// ----------------------------------------------------------------------------
// rct_ctrl
// Controller: accepts items, sequences the table scan and hands the count to
// the output register.
// ----------------------------------------------------------------------------
module rct_ctrl
  import rct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  output logic     in_ready_o,
  input  rct_sts_t sts_i,
  output rct_cmd_t cmd_o
);

  rct_state_e state_q, state_d;
  rct_op_e    op;

  assign op = rct_op_e'(in_op_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op)
            OP_SET: begin
              cmd_o.write_entry = 1'b1;
            end
            OP_QUERY: begin
              cmd_o.start_query = 1'b1;
              state_d = sts_i.query_empty ? ST_RESULT : ST_SCAN;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/rct_dp.sv @@
// ----------------------------------------------------------------------------
// rct_dp
// Datapath: value table, scan address counter, range compare, match counter
// and output register.
// ----------------------------------------------------------------------------
module rct_dp
  import rct_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rct_cmd_t              cmd_i,
  output rct_sts_t              sts_o,
  input  logic [USE_BITS-1:0]   entries_i,
  input  logic [IDX_BITS-1:0]   entry_index_i,
  input  logic [VALUE_BITS-1:0] new_value_i,
  input  logic [VALUE_BITS-1:0] range_low_i,
  input  logic [VALUE_BITS-1:0] range_high_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [COUNT_BITS-1:0] out_count_o
);

  logic [VALUE_BITS-1:0] low_q, high_q;
  logic [ADDR_BITS-1:0]  last_q, last_d;
  logic [ADDR_BITS-1:0]  addr_q;
  logic                  rd_vld_q;
  logic                  match_q, match_vld_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  out_valid_q;
  logic [COUNT_BITS-1:0] out_count_q;
  logic [VALUE_BITS-1:0] rdata;
  logic                  set_ok;
  logic [ADDR_BITS-1:0]  waddr;

  assign set_ok = (32'(entry_index_i) >= 32'd1) &&
                  (32'(entry_index_i) <= 32'(TABLE_DEPTH));
  assign waddr  = ADDR_BITS'(entry_index_i - IDX_BITS'(1));
  assign last_d = (32'(entries_i) >= 32'(TABLE_DEPTH)) ?
                  ADDR_BITS'(TABLE_DEPTH - 1) :
                  ADDR_BITS'(entries_i - USE_BITS'(1));

  rct_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_entry && set_ok),
    .waddr_i (waddr),
    .wdata_i (new_value_i),
    .re_i    (cmd_i.issue),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_query) begin
      low_q  <= range_low_i;
      high_q <= range_high_i;
      last_q <= last_d;
    end
    match_q <= (rdata >= low_q) && (rdata <= high_q);
    if (cmd_i.load_out) begin
      out_count_q <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      match_vld_q <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q    <= cmd_i.issue;
      match_vld_q <= rd_vld_q;
      if (cmd_i.start_query) begin
        addr_q  <= '0;
        count_q <= '0;
      end else begin
        if (cmd_i.issue) begin
          addr_q <= addr_q + ADDR_BITS'(1);
        end
        if (match_vld_q && match_q) begin
          count_q <= count_q + COUNT_BITS'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.query_empty = (range_low_i > range_high_i) || (entries_i == '0);
  assign sts_o.last_issue  = (addr_q == last_q);
  assign sts_o.pipe_empty  = !rd_vld_q && !match_vld_q;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;

endmodule

@@ hdl/range_count_table.sv @@
// A set item with an index from 1 to 1024 writes the table at its transfer edge. A query
// reads each entry in use once, drains the read and compare registers and loads its count
// into the output register when it is free; an empty range or zero entries in use skip the scan.
// Set items are taken one per cycle while no query is in progress; no item is taken until
// a query has loaded its count, so an output stall also holds the input.
// Reset clears control state and sets entries_in_use to 1024; the table is undefined.
// ----------------------------------------------------------------------------
// range_count_table
// Table of numbered values with single-entry writes and inclusive range
// count queries over the entries in use.
// ----------------------------------------------------------------------------
module range_count_table
  import rct_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rct_in_if.sink                in_i,
  rct_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  logic [USE_BITS-1:0] entries_q;
  rct_reg_e            reg_sel;
  logic                cfg_write;
  rct_cmd_t            cmd;
  rct_sts_t            sts;

  assign reg_sel   = rct_reg_e'(paddr[PADDR_BITS-1]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= USE_BITS'(ENTRIES_RESET);
    end else if (cfg_write && (reg_sel == REG_ENTRIES_IN_USE)) begin
      entries_q <= pwdata[USE_BITS-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ENTRIES_IN_USE: prdata = PDATA_BITS'(entries_q);
      REG_UNUSED:         prdata = '0;
      default:            prdata = '0;
    endcase
  end

  rct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rct_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .entries_i     (entries_q),
    .entry_index_i (in_i.entry_index),
    .new_value_i   (in_i.new_value),
    .range_low_i   (in_i.range_low),
    .range_high_i  (in_i.range_high),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_count_o   (out_o.match_count)
  );

  // A query transfer always blocks further input in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.operation == OP_QUERY)) |=> !in_i.ready)
    else $error("input taken right after a query transfer");

  // A set item never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.operation == OP_SET) && !out_o.valid)
      |=> !out_o.valid)
    else $error("result appeared after a set item");

  // The count never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (32'(out_o.match_count) <= 32'(TABLE_DEPTH)))
    else $error("match count above table depth");

  // A configuration write to entries_in_use takes effect at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_write && (reg_sel == REG_ENTRIES_IN_USE))
      |=> (entries_q == $past(pwdata[USE_BITS-1:0])))
    else $error("entries_in_use write lost");

endmodule

@@ verif/range_count_table_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_count_table_test
// Self-checking bench for the range count table. A short table of directed
// set and query transfers is followed by a load of the leading entries and by
// random phases at several table-size settings, from zero to the loaded span.
// A shadow copy of the table predicts every match count but those of the typed
// directed rows, which carry their own. Both channels pause and stall at random.
// ----------------------------------------------------------------------------
module range_count_table_test;
  import rct_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = TABLE_DEPTH + 16;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_PAUSE     = 6;
  localparam int REPORT_LIMIT  = 10;
  localparam int DIR_ROWS      = 24;
  localparam int PHASES        = 10;
  localparam int LOAD_ENTRIES  = 320;

  localparam logic [VALUE_BITS-1:0] VMAX   = '1;
  localparam logic [VALUE_BITS-1:0] ALT_A  = 30'h2AAA_AAAA;
  localparam logic [VALUE_BITS-1:0] ALT_B  = 30'h1555_5555;
  localparam logic [PADDR_BITS-1:0] USE_ADDR = PADDR_BITS'(4 * int'(REG_ENTRIES_IN_USE));

  typedef struct packed {
    rct_op_e               op;
    logic [IDX_BITS-1:0]   idx;
    logic [VALUE_BITS-1:0] nv;
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
    logic                  typed;
    logic [COUNT_BITS-1:0] count;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_SET,   11'd1,    30'd0, 30'd0, 30'd0,   1'b0, 11'd0},
    '{OP_SET,   11'd2,    VMAX,  30'd0, 30'd0,   1'b0, 11'd0},
    '{OP_SET,   11'd3,    30'd5, 30'd0, 30'd0,   1'b0, 11'd0},
    '{OP_SET,   11'd4,    30'd5, 30'd0, 30'd0,   1'b0, 11'd0},
    '{OP_QUERY, 11'd0,    30'd0, 30'd0, VMAX,    1'b1, 11'd4},
    '{OP_QUERY, 11'd0,    30'd0, 30'd5, 30'd5,   1'b1, 11'd2},
    '{OP_QUERY, 11'd0,    30'd0, VMAX,  VMAX,    1'b1, 11'd1},
    '{OP_QUERY, 11'd0,    30'd0, 30'd0, 30'd0,   1'b1, 11'd1},
    '{OP_QUERY, 11'd0,    30'd0, 30'd6, 30'd5,   1'b1, 11'd0},
    '{OP_QUERY, 11'd0,    30'd0, VMAX,  30'd0,   1'b1, 11'd0},
    '{OP_SET,   11'd0,    30'd5, 30'd0, 30'd0,   1'b0, 11'd0},
    '{OP_SET,   11'd1025, 30'd5, 30'd0, 30'd0,   1'b0, 11'd0},
    '{OP_SET,   11'd2047, 30'd5, VMAX,  VMAX,    1'b0, 11'd0},
    '{OP_SET,   11'd9,    30'd5, 30'd0, 30'd0,   1'b0, 11'd0},
    '{OP_SET,   11'd1024, VMAX,  30'd0, 30'd0,   1'b0, 11'd0},
    '{OP_QUERY, 11'd2047, VMAX,  30'd5, 30'd5,   1'b1, 11'd2},
    '{OP_SET,   11'd3,    VMAX,  30'd0, 30'd0,   1'b0, 11'd0},
    '{OP_QUERY, 11'd0,    30'd0, 30'd1, VMAX,    1'b1, 11'd3},
    '{OP_SET,   11'd1,    30'd6, 30'd0, 30'd0,   1'b0, 11'd0},
    '{OP_QUERY, 11'd0,    30'd0, 30'd5, 30'd6,   1'b0, 11'd0},
    '{OP_QUERY, 11'd0,    30'd0, ALT_A, ALT_B,   1'b1, 11'd0},
    '{OP_SET,   11'd4,    ALT_A, 30'd0, 30'd0,   1'b0, 11'd0},
    '{OP_QUERY, 11'd0,    30'd0, ALT_A, ALT_A,   1'b0, 11'd0},
    '{OP_QUERY, 11'd0,    30'd0, 30'd0, VMAX - 1, 1'b0, 11'd0}
  };

  int unsigned phase_use   [PHASES] = '{16, 1, 0, 2, 320, 64, 5, 300, 33, 0};
  int unsigned phase_items [PHASES] = '{30, 20, 10, 10, 30, 30, 20, 30, 26, 30};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  rct_in_if  in_if ();
  rct_out_if out_if ();

  range_count_table i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [VALUE_BITS-1:0] salary_shadow [TABLE_DEPTH];
  int unsigned           shadow_in_use;
  logic [COUNT_BITS-1:0] pending_counts [$];
  logic [COUNT_BITS-1:0] want_count;

  int send_quiet;
  int take_quiet;
  int mismatch_count;
  int set_count;
  int query_count;
  int setting_count;
  int counts_checked;
  int cycle_count;

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic int draw_pause(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MAX_PAUSE);
  endfunction

  function automatic int unsigned scan_span();
    return (shadow_in_use > TABLE_DEPTH) ? TABLE_DEPTH : shadow_in_use;
  endfunction

  function automatic logic [COUNT_BITS-1:0] count_salaries_in_range(
    logic [VALUE_BITS-1:0] lo,
    logic [VALUE_BITS-1:0] hi
  );
    int unsigned hits;
    hits = 0;
    if (lo <= hi) begin
      for (int i = 0; i < scan_span(); i++) begin
        if (salary_shadow[i] >= lo && salary_shadow[i] <= hi) begin
          hits++;
        end
      end
    end
    return COUNT_BITS'(hits);
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_salary();
    case ($urandom_range(0, 9))
      0: begin
        return '0;
      end
      1: begin
        return VMAX;
      end
      2, 3, 4, 5: begin
        return VALUE_BITS'($urandom_range(0, 15));
      end
      default: begin
        return VALUE_BITS'($urandom);
      end
    endcase
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_stored_salary();
    int unsigned span;
    span = (scan_span() == 0) ? 1 : scan_span();
    return salary_shadow[$urandom_range(0, span - 1)];
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want, got, cycle_count);
    end
  endtask

  task automatic post_item(
    rct_op_e               op,
    logic [IDX_BITS-1:0]   idx,
    logic [VALUE_BITS-1:0] nv,
    logic [VALUE_BITS-1:0] lo,
    logic [VALUE_BITS-1:0] hi,
    logic                  typed,
    logic [COUNT_BITS-1:0] typed_count
  );
    int                    pause;
    logic [COUNT_BITS-1:0] want;
    pause = draw_pause(send_quiet);
    @(negedge clk_i);
    if (pause > 0) begin
      in_if.valid <= 1'b0;
      repeat (pause) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.entry_index <= idx;
    in_if.new_value   <= nv;
    in_if.range_low   <= lo;
    in_if.range_high  <= hi;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (op == OP_SET) begin
      if (idx >= 1 && idx <= TABLE_DEPTH) begin
        salary_shadow[idx - 1] = nv;
      end
      set_count++;
    end else begin
      want = typed ? typed_count : count_salaries_in_range(lo, hi);
      pending_counts = {pending_counts, want};
      query_count++;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [PDATA_BITS-1:0] wdata,
                            output logic [PDATA_BITS-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= USE_ADDR;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_entries_in_use(int unsigned n);
    logic [PDATA_BITS-1:0] rd;
    apb_access(1'b1, PDATA_BITS'(n), rd);
    apb_access(1'b0, '0, rd);
    shadow_in_use = n & ((1 << USE_BITS) - 1);
    if (rd[USE_BITS-1:0] !== USE_BITS'(n)) begin
      flag_mismatch("entries_in_use read-back", n, rd);
    end
    setting_count++;
  endtask

  task automatic post_random_item();
    logic [IDX_BITS-1:0]   idx;
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
    int unsigned           span;
    span = (scan_span() == 0) ? 1 : scan_span();
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          lo = VALUE_BITS'($urandom_range(0, 15));
          hi = VALUE_BITS'($urandom_range(0, 15));
        end
        4, 5: begin
          lo = pick_stored_salary();
          hi = pick_stored_salary();
        end
        6: begin
          lo = pick_stored_salary();
          hi = lo;
        end
        7: begin
          lo = '0;
          hi = VMAX;
        end
        default: begin
          lo = VALUE_BITS'($urandom);
          hi = VALUE_BITS'($urandom);
        end
      endcase
      post_item(OP_QUERY, IDX_BITS'($urandom_range(0, 2047)), VALUE_BITS'($urandom),
                lo, hi, 1'b0, '0);
    end else begin
      case ($urandom_range(0, 9))
        7, 8: begin
          idx = IDX_BITS'($urandom_range(1, TABLE_DEPTH));
        end
        9: begin
          idx = ($urandom_range(0, 1) == 1) ? '0 : IDX_BITS'($urandom_range(1025, 2047));
        end
        default: begin
          idx = IDX_BITS'($urandom_range(1, span));
        end
      endcase
      post_item(OP_SET, idx, pick_salary(), VALUE_BITS'($urandom), VALUE_BITS'($urandom),
                1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d counts outstanding",
               cycle_count, pending_counts.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_counts.size() == 0) begin
        flag_mismatch("match_count with no query pending", '0, out_if.match_count);
      end else begin
        want_count = pending_counts.pop_front();
        counts_checked++;
        if (out_if.match_count !== want_count) begin
          flag_mismatch("match_count", want_count, out_if.match_count);
        end
      end
    end
  end

  initial begin
    int pause;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      pause = draw_pause(take_quiet);
      @(negedge clk_i);
      if (pause > 0) begin
        out_if.ready <= 1'b0;
        repeat (pause) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
    end
  end

  initial begin
    logic [PDATA_BITS-1:0] rd;
    int unsigned           use_now;
    int unsigned           done;

    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.operation   = OP_SET;
    in_if.entry_index = '0;
    in_if.new_value   = '0;
    in_if.range_low   = '0;
    in_if.range_high  = '0;
    shadow_in_use     = ENTRIES_RESET;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      salary_shadow[i] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    apb_access(1'b0, '0, rd);
    if (rd[USE_BITS-1:0] !== USE_BITS'(ENTRIES_RESET)) begin
      flag_mismatch("entries_in_use after reset", ENTRIES_RESET, rd);
    end

    set_entries_in_use(4);
    for (int r = 0; r < DIR_ROWS; r++) begin
      post_item(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].nv, dir_rows[r].lo,
                dir_rows[r].hi, dir_rows[r].typed, dir_rows[r].count);
    end
    drain();

    // Every entry that a query may scan must hold a written value first.
    for (int i = 1; i <= LOAD_ENTRIES; i++) begin
      post_item(OP_SET, IDX_BITS'(i), pick_salary(), VALUE_BITS'($urandom),
                VALUE_BITS'($urandom), 1'b0, '0);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      use_now = (p == PHASES - 1) ? $urandom_range(1, 64) : phase_use[p];
      set_entries_in_use(use_now);
      done = 0;
      while (done < phase_items[p]) begin
        if (done == phase_items[p] / 2) begin
          drain();
        end
        post_random_item();
        if (in_if.operation == OP_QUERY ||
            (in_if.entry_index >= 1 && in_if.entry_index <= TABLE_DEPTH)) begin
          done++;
        end
      end
      drain();
    end

    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_counts.size() != 0) begin
      mismatch_count += pending_counts.size();
    end

    $display("Sent %0d set and %0d query transfers over %0d table-size settings.",
             set_count, query_count, setting_count);
    $display("Checked %0d match counts; %0d mismatches.", counts_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
